[hdl/aes128_cbc_encrypt_unit_defines.svh]
// Assertion macros shared by the AES-128 CBC encryption unit.
`ifndef AES128_CBC_ENCRYPT_UNIT_DEFINES_SVH
`define AES128_CBC_ENCRYPT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AES_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[hdl/aes_pkg.sv]
// Shared types, constants and round functions of the AES-128 CBC encryption unit.
package aes_pkg;

	localparam int unsigned KEY_WORDS = 44;
	localparam int unsigned KADDR_W = 6;
	localparam int unsigned ROUND_W = 4;
	localparam int unsigned LAST_ROUND = 10;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// Round constants, one per group of four schedule words.
	localparam logic [7:0] RCON [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
	};

	// Status of the key expander, read by the top-level unit.
	typedef struct packed {
		logic busy;
		logic done;
	} kexp_status_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	// SubBytes and ShiftRows; byte 0 of the state sits in bits 127:120.
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

endpackage

[hdl/aes128_cbc_encrypt_unit.sv]
// AES-128 CBC encryption unit: one block per transfer, ciphertext chained to the next block.
// Steps from input transfer to result valid: IV xor, key add, ten rounds, capture.
// The unit holds one block at a time; the next input waits until the result is taken.
// After a key write the schedule memory is refilled before input is taken.
// Reset (arst_n low) zeroes the key and IV and starts expanding the all-zero key.
// Round keys come from a registered memory, each read in the cycle before its use.
`include "aes128_cbc_encrypt_unit_defines.svh"
module aes128_cbc_encrypt_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // plain_high [63:0], plain_low [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // cipher_high [63:0], cipher_low [127:64]
);
	logic [63:0] key_high_q, key_low_q;
	logic kstart_q;
	logic kpend_q;
	aes_pkg::kexp_status_t kstat;
	logic core_busy, core_done, core_start;
	logic [127:0] cipher, rkey;
	logic [aes_pkg::ROUND_W-1:0] rd_round;
	logic out_valid_q;
	logic [127:0] out_q;

	// A key write restarts the expansion on the next cycle; reset kicks one off too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			kstart_q <= 1'b1;
			kpend_q <= 1'b1;
		end else begin
			kstart_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == aes_pkg::CFG_KEY_HIGH) key_high_q <= cfg_data;
				else key_low_q <= cfg_data;
				kstart_q <= 1'b1;
				kpend_q <= 1'b1;
			end else if (kstat.done) begin
				kpend_q <= 1'b0;
			end
		end
	end

	aes_key_expand u_kexp (
		.clk(clk), .arst_n(arst_n), .start(kstart_q),
		.key({key_high_q, key_low_q}), .rd_round(rd_round),
		.rd_key(rkey), .status(kstat)
	);

	// The core holds one block; the output register must be free before a new one starts.
	assign s_tready = !kpend_q && !kstart_q && !kstat.busy && !core_busy && !core_done
		&& !out_valid_q;
	assign core_start = s_tvalid && s_tready;

	aes_round_core u_core (
		.clk(clk), .arst_n(arst_n), .start(core_start),
		.plain({s_tdata[63:0], s_tdata[127:64]}), .rkey(rkey), .rd_round(rd_round),
		.busy(core_busy), .done(core_done), .cipher(cipher)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) out_q <= cipher;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q[63:0], out_q[127:64]};

	`AES_ASSERT_NEVER(a_one_block, clk, arst_n, core_done && out_valid_q, "result overwritten")
	`AES_ASSERT_IMPL(a_no_accept_kexp, clk, arst_n, kstat.busy |-> !s_tready, "accept during expand")
endmodule

[hdl/aes_key_expand.sv]
// Key schedule sequencer and the round key memory it fills.
`include "aes128_cbc_encrypt_unit_defines.svh"
module aes_key_expand (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [127:0]                 key,
	input  logic [aes_pkg::ROUND_W-1:0]  rd_round,
	output logic [127:0]                 rd_key,
	output aes_pkg::kexp_status_t        status
);
	// Words are kept four to a row so one round key reads in a single access.
	logic [127:0] mem [11];
	logic [127:0] prev_q;
	logic [aes_pkg::ROUND_W-1:0] row_q;
	logic busy_q;
	logic done_q;
	logic [31:0] w0, w1, w2, w3, t;

	always_comb begin
		t = aes_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {aes_pkg::RCON[row_q - 4'd1], 24'h0};
		w0 = prev_q[127:96] ^ t;
		w1 = prev_q[95:64] ^ w0;
		w2 = prev_q[63:32] ^ w1;
		w3 = prev_q[31:0] ^ w2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			row_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			row_q <= 4'd1;
		end else if (busy_q) begin
			row_q <= row_q + 4'd1;
			if (row_q == 4'(aes_pkg::LAST_ROUND)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mem[0] <= key;
			prev_q <= key;
		end else if (busy_q) begin
			mem[row_q] <= {w0, w1, w2, w3};
			prev_q <= {w0, w1, w2, w3};
		end
		rd_key <= mem[rd_round];
	end

	assign status = '{busy: busy_q, done: done_q};

	`AES_ASSERT_NEVER(a_busy_done, clk, arst_n, busy_q && done_q, "expander busy and done")
	`AES_ASSERT_IMPL(a_row_range, clk, arst_n, busy_q |-> (row_q != 4'd0), "bad schedule row")
endmodule

[hdl/aes_round_core.sv]
// Iterative AES round datapath with the CBC chaining register.
`include "aes128_cbc_encrypt_unit_defines.svh"
module aes_round_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [127:0]                 plain,
	input  logic [127:0]                 rkey,
	output logic [aes_pkg::ROUND_W-1:0]  rd_round,
	output logic                         busy,
	output logic                         done,
	output logic [127:0]                 cipher
);
	logic [127:0] state_q;
	logic [127:0] chain_q;
	logic [aes_pkg::ROUND_W-1:0] rnd_q;
	logic busy_q;
	logic first_q;
	logic [127:0] ss;

	// Key row is read in the cycle before its use.
	assign rd_round = start ? '0 : first_q ? rnd_q + 4'd1
		: (rnd_q >= 4'(aes_pkg::LAST_ROUND - 1)) ? 4'(aes_pkg::LAST_ROUND) : rnd_q + 4'd2;
	assign ss = aes_pkg::sub_shift(state_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			first_q <= 1'b0;
			rnd_q <= '0;
			done <= 1'b0;
			chain_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (!first_q) begin
					rnd_q <= rnd_q + 4'd1;
				end
				if (rnd_q == 4'(aes_pkg::LAST_ROUND)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					chain_q <= state_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= plain ^ chain_q;
		end else if (busy_q && rnd_q != 4'(aes_pkg::LAST_ROUND)) begin
			if (first_q) begin
				state_q <= state_q ^ rkey;
			end else if (rnd_q == 4'(aes_pkg::LAST_ROUND - 1)) begin
				state_q <= ss ^ rkey;
			end else begin
				state_q <= aes_pkg::mix_columns(ss) ^ rkey;
			end
		end
	end

	assign busy = busy_q;
	assign cipher = state_q;

	`AES_ASSERT_IMPL(a_done_pulse, clk, arst_n, done |=> !done, "done held")
	`AES_ASSERT_NEVER(a_start_busy, clk, arst_n, start && busy_q, "start while busy")
endmodule
